### src/bpr_pkg.sv
package bpr_pkg;

  localparam logic [31:0] CAP_MAX = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_STORED  = 3'd2,
    ST_EVICT   = 3'd3,
    ST_DISCARD = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch_last;
    logic move;
    logic append;
    logic evict_wr;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic empty;
    logic full;
    logic last_issue;
    logic hit;
    logic evict;
    logic out_busy;
  } stat_t;

endpackage

### src/bpr_ctrl.sv
module bpr_ctrl
  import bpr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  action,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!action) begin
            state_next = stat.empty ? S_DONE : S_SCAN;
          end else begin
            state_next = stat.full ? S_SCAN : S_DECIDE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      // last read of the scan is compared here
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (!stat.act) begin
          if (stat.hit) begin
            cmd.fetch_last = 1'b1;
            state_next = S_MOVE;
          end
        end else if (!stat.full) begin
          cmd.append = 1'b1;
        end else if (stat.evict) begin
          cmd.evict_wr = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted beat did not start work");

  a_move_after_decide: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |-> $past(state) == S_DECIDE)
    else $error("slot move without fetch of last entry");

endmodule

### src/bpr_datapath.sv
module bpr_datapath
  import bpr_pkg::*;
#(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        action,
  input  logic [31:0] req_size,
  input  logic [31:0] rel_capacity,
  input  logic [15:0] rel_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [31:0] out_capacity,
  output logic [4:0]  pool_count
);

  localparam int IW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW  = $clog2(POOL_DEPTH + 1);
  localparam int HIN = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  logic [31:0]            cap_mem [POOL_DEPTH];
  logic [HANDLE_BITS-1:0] hdl_mem [POOL_DEPTH];

  logic        act;
  logic [31:0] req;
  logic [31:0] rcap;
  logic [15:0] rh;
  logic        full;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic          cmp_en;
  logic [IW-1:0] cmp_idx;
  logic [31:0]            rd_cap;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic                   hit;
  logic [IW-1:0]          hit_idx;
  logic [31:0]            hit_cap;
  logic [HANDLE_BITS-1:0] hit_hdl;
  logic [31:0]            min_cap;
  logic [IW-1:0]          min_idx;
  logic [HANDLE_BITS-1:0] min_hdl;

  logic [IW-1:0]          last;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [31:0]            wr_cap;
  logic [HANDLE_BITS-1:0] wr_hdl;
  logic [HANDLE_BITS-1:0] rel_hdl_st;
  logic                   evict;
  logic [2:0]             res_status;
  logic [15:0]            res_handle;
  logic [31:0]            res_cap;

  assign last       = IW'(count - CW'(1));
  assign rd_addr    = cmd.fetch_last ? last : idx;
  assign rel_hdl_st = HANDLE_BITS'(rh[HIN-1:0]);
  assign evict      = (min_cap < rcap);

  always_comb begin
    wr_en   = cmd.append | cmd.move | cmd.evict_wr;
    wr_addr = count[IW-1:0];
    wr_cap  = rcap;
    wr_hdl  = rel_hdl_st;
    if (cmd.move) begin
      // last entry fills the hole left by the hit
      wr_addr = hit_idx;
      wr_cap  = rd_cap;
      wr_hdl  = rd_hdl;
    end else if (cmd.evict_wr) begin
      wr_addr = min_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cap_mem[wr_addr] <= wr_cap;
      hdl_mem[wr_addr] <= wr_hdl;
    end
    if (cmd.scan || cmd.fetch_last) begin
      rd_cap <= cap_mem[rd_addr];
      rd_hdl <= hdl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      req  <= req_size;
      rcap <= rel_capacity;
      rh   <= rel_handle;
      full <= (count == CW'(POOL_DEPTH));
    end
    cmp_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cmp_en <= 1'b0;
      idx    <= '0;
      hit    <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.scan) begin
        idx <= idx + 1'b1;
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.move) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmp_en && !act && !hit && rd_cap >= req) begin
        hit <= 1'b1;
      end
    end
  end

  // compare stage of the scan, one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_cap <= CAP_MAX;
      min_idx <= '0;
    end else if (cmp_en) begin
      if (!act && !hit && rd_cap >= req) begin
        hit_idx <= cmp_idx;
        hit_cap <= rd_cap;
        hit_hdl <= rd_hdl;
      end
      if (act && rd_cap < min_cap) begin
        min_cap <= rd_cap;
        min_idx <= cmp_idx;
        min_hdl <= rd_hdl;
      end
    end
  end

  always_comb begin
    res_status = ST_STORED;
    res_handle = '0;
    res_cap    = '0;
    if (!act) begin
      if (hit) begin
        res_status = ST_HIT;
        res_handle = 16'(hit_hdl[HIN-1:0]);
        res_cap    = hit_cap;
      end else begin
        res_status = ST_MISS;
        res_cap    = req;
      end
    end else if (full) begin
      if (evict) begin
        res_status = ST_EVICT;
        res_handle = 16'(min_hdl[HIN-1:0]);
        res_cap    = min_cap;
      end else begin
        res_status = ST_DISCARD;
        res_handle = 16'(rh[HIN-1:0]);
        res_cap    = rcap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status       <= res_status;
      out_handle   <= res_handle;
      out_capacity <= res_cap;
      pool_count   <= 5'(count);
    end
  end

  always_comb begin
    stat.act        = act;
    stat.empty      = (count == '0);
    stat.full       = (count == CW'(POOL_DEPTH));
    stat.last_issue = (CW'(idx) == count - CW'(1));
    stat.hit        = hit;
    stat.evict      = evict;
    stat.out_busy   = out_valid & out_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_DEPTH))
    else $error("pool count beyond depth");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    cmd.evict_wr |-> full && act)
    else $error("eviction on a pool that is not full");

  a_move_needs_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> hit && !act && count != '0)
    else $error("slot move without a hit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("result beat overwritten while stalled");

endmodule

### src/buffer_pool_recycler_core.sv
// each item, from its accept: an acquire on an empty pool goes straight to its result; a release
// into a pool with room appends in the decide state; an acquire on a non-empty pool or a release
// into a full pool scans the n held buffers, then drains and decides; an acquire hit also moves a slot
// the result beat is registered and goes valid on the publish in the done state
// one item at a time, the scan reads one slot per cycle; a stalled result holds the next item
// reset (rst, synchronous) empties the pool and drops any pending result beat
module buffer_pool_recycler_core
  import bpr_pkg::*;
#(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] req_size,
  input  logic [31:0] rel_capacity,
  input  logic [15:0] rel_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [31:0] out_capacity,
  output logic [4:0]  pool_count
);

  cmd_t  cmd;
  stat_t stat;

  bpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpr_datapath #(
    .POOL_DEPTH  (POOL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .req_size     (req_size),
    .rel_capacity (rel_capacity),
    .rel_handle   (rel_handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_handle   (out_handle),
    .out_capacity (out_capacity),
    .pool_count   (pool_count)
  );

endmodule

### tb/tb_buffer_pool_recycler_core.sv
module tb_buffer_pool_recycler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bpr_pkg::*;

  localparam int DEPTH          = 16;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    status_t     st;
    logic [15:0] handle;
    logic [31:0] capacity;
    logic [4:0]  count;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [31:0] req_size = '0;
  logic [31:0] rel_capacity = '0;
  logic [15:0] rel_handle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] out_handle;
  logic [31:0] out_capacity;
  logic [4:0]  pool_count;

  // predicted pool contents
  logic [31:0] pool_cap [DEPTH];
  logic [15:0] pool_hnd [DEPTH];
  int          pool_held = 0;

  pool_result_t pending_results[$];
  pool_result_t check_want;
  int           status_seen [5];
  int           mismatch_count = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           holdoff_seq = 0;
  int           holdoff_seen = 0;
  int           hold_left = 0;

  buffer_pool_recycler_core #(
    .POOL_DEPTH  (DEPTH),
    .HANDLE_BITS (16)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .req_size     (req_size),
    .rel_capacity (rel_capacity),
    .rel_handle   (rel_handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_handle   (out_handle),
    .out_capacity (out_capacity),
    .pool_count   (pool_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("** buffer_pool_recycler_core: FAILED **");
      $finish;
    end
  end

  function automatic pool_result_t recycle_predict(input logic act, input logic [31:0] rs,
                                                   input logic [31:0] rc,
                                                   input logic [15:0] rh);
    pool_result_t r;
    int           hit_pos;
    int           min_pos;
    logic [31:0]  min_cap;
    r.st       = ST_MISS;
    r.handle   = '0;
    r.capacity = '0;
    if (act == 1'b0) begin
      hit_pos = -1;
      for (int i = 0; i < pool_held; i++) begin
        if (hit_pos < 0 && pool_cap[i] >= rs) hit_pos = i;
      end
      if (hit_pos >= 0) begin
        r.st       = ST_HIT;
        r.handle   = pool_hnd[hit_pos];
        r.capacity = pool_cap[hit_pos];
        // last held slot fills the hole
        pool_cap[hit_pos] = pool_cap[pool_held - 1];
        pool_hnd[hit_pos] = pool_hnd[pool_held - 1];
        pool_held--;
      end else begin
        r.capacity = rs;
      end
    end else if (pool_held < DEPTH) begin
      pool_cap[pool_held] = rc;
      pool_hnd[pool_held] = rh;
      pool_held++;
      r.st = ST_STORED;
    end else begin
      min_cap = CAP_MAX;
      min_pos = 0;
      for (int i = 0; i < pool_held; i++) begin
        if (pool_cap[i] < min_cap) begin
          min_cap = pool_cap[i];
          min_pos = i;
        end
      end
      if (min_cap < rc) begin
        r.st       = ST_EVICT;
        r.handle   = pool_hnd[min_pos];
        r.capacity = min_cap;
        pool_cap[min_pos] = rc;
        pool_hnd[min_pos] = rh;
      end else begin
        r.st       = ST_DISCARD;
        r.handle   = rh;
        r.capacity = rc;
      end
    end
    r.count = 5'(pool_held);
    return r;
  endfunction

  function automatic logic [31:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 32'($urandom_range(0, 255));
    else if (sel < 7) return 32'($urandom_range(0, 65535));
    else if (sel < 9) return 32'($urandom);
    else return CAP_MAX - 32'($urandom_range(0, 3));
  endfunction

  task automatic send_beat(input logic act, input logic [31:0] rs, input logic [31:0] rc,
                           input logic [15:0] rh);
    pool_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    req_size     <= rs;
    rel_capacity <= rc;
    rel_handle   <= rh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = recycle_predict(act, rs, rc, rh);
    pending_results = {pending_results, r};
    beats_sent++;
  endtask

  task automatic acquire(input logic [31:0] rs);
    send_beat(1'b0, rs, 32'($urandom), 16'($urandom));
  endtask

  task automatic release_buf(input logic [31:0] rc, input logic [15:0] rh);
    send_beat(1'b1, 32'($urandom), rc, rh);
  endtask

  // result side: random stall, or a long holdoff when asked
  always @(negedge clk) begin
    if (holdoff_seq != holdoff_seen) begin
      holdoff_seen = holdoff_seq;
      hold_left    = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: status %0d handle %h capacity %h count %0d",
                   status, out_handle, out_capacity, pool_count);
      end else begin
        check_want = pending_results.pop_front();
        status_seen[check_want.st]++;
        beats_checked++;
        if (status !== check_want.st || out_handle !== check_want.handle ||
            out_capacity !== check_want.capacity || pool_count !== check_want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch on result %0d:", beats_checked);
            $display("  expected status %0d handle %h capacity %h count %0d",
                     check_want.st, check_want.handle, check_want.capacity,
                     check_want.count);
            $display("  actual   status %0d handle %h capacity %h count %0d",
                     status, out_handle, out_capacity, pool_count);
          end
        end
      end
    end
  end

  task automatic test_empty_pool_misses();
    acquire(32'd0);
    acquire(CAP_MAX);
  endtask

  task automatic test_fill_pool();
    logic [31:0] cap;
    logic [15:0] hnd;
    for (int i = 0; i < DEPTH; i++) begin
      // two slots tie on the smallest capacity
      if (i == 3 || i == 9) cap = 32'd7;
      else if (i == DEPTH - 1) cap = CAP_MAX;
      else cap = 32'd1000 + 32'(i * 37);
      if (i == 0) hnd = 16'h0000;
      else if (i == DEPTH - 1) hnd = 16'hffff;
      else hnd = 16'h1000 + 16'(i);
      release_buf(cap, hnd);
    end
  endtask

  task automatic test_full_pool_release();
    release_buf(32'd7, 16'h5a5a);   // equal to smallest: discarded
    release_buf(32'd8, 16'habcd);   // evicts the first of the tied slots
    release_buf(32'd0, 16'h0001);   // below smallest: discarded
  endtask

  task automatic test_acquire_reorder();
    acquire(32'd0);
    acquire(CAP_MAX);               // hits the buffer moved into slot 0
    acquire(32'd8);
    release_buf(32'd0, 16'h0000);
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    int release_pct;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    release_pct   = 50;
    for (int k = 0; k < n; k++) begin
      // switch at random between filling, balanced and draining bursts so the pool hits both ends
      if (k % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: release_pct = 85;
          1: release_pct = 50;
          default: release_pct = 20;
        endcase
      end
      if ($urandom_range(0, 99) < release_pct)
        release_buf(pick_size(), 16'($urandom));
      else
        acquire(pick_size());
    end
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    holdoff_seq++;
    for (int k = 0; k < 12; k++) begin
      if (k % 2 == 0) release_buf(pick_size(), 16'($urandom));
      else acquire(pick_size());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_empty_pool_misses();
    test_fill_pool();
    test_full_pool_release();
    test_acquire_reorder();
    test_random_traffic(170, 27, 51);
    test_random_traffic(170, 51, 27);
    test_output_holdoff();
    test_random_traffic(170, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request beats sent, %0d result beats checked, %0d mismatches",
             beats_sent, beats_checked, mismatch_count);
    $display("hits %0d, misses %0d, stored %0d, evictions %0d, discards %0d",
             status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_STORED],
             status_seen[ST_EVICT], status_seen[ST_DISCARD]);
    if (mismatch_count == 0) begin
      $display("** buffer_pool_recycler_core: PASSED **");
    end else begin
      $display("** buffer_pool_recycler_core: FAILED **");
    end
    $finish;
  end

endmodule

### buffer_pool_recycler_core.f
src/bpr_pkg.sv
src/bpr_ctrl.sv
src/bpr_datapath.sv
src/buffer_pool_recycler_core.sv
tb/tb_buffer_pool_recycler_core.sv
